// File: sv/clos_pkg.sv
// ----------------------------------------------------------------------------
// clos_pkg: shared types and constants for the binary 3x3 closing block
// Register indexes, stream field codes, frame size reset values and the
// border mask that travels from the position counters to the window units.
// ----------------------------------------------------------------------------
package clos_pkg;

    // Configuration register widths and indexes
    localparam int CFG_W_BITS    = 11;
    localparam int CFG_H_BITS    = 13;
    localparam int CFG_DATA_BITS = 13;
    localparam int CFG_IDX_BITS  = 1;

    localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [CFG_W_BITS-1:0] RESET_WIDTH  = 11'd640;
    localparam logic [CFG_H_BITS-1:0] RESET_HEIGHT = 13'd480;

    // Stream words
    localparam int TDATA_BITS = 8;
    localparam logic OP_FLUSH = 1'b1;

    // Which sides of a 3x3 window fall outside the image
    typedef struct packed {
        logic top;
        logic bottom;
        logic left;
        logic right;
    } win_mask_t;

endpackage

// File: sv/binary_closing_3x3.sv
// Latency: a closed pixel is registered on the word that brings input pixel k+2W+2
//   and is offered on the master side in the next cycle.
// Throughput: one word per cycle while the master side takes results;
//   frames with W*H below 2W+3 hold s_tready low at frame end until output catches up.
// Reset: aresetn is synchronous, active low; counters, size registers and the
//   valid flag reset, while line memories and data registers keep their contents.
// ----------------------------------------------------------------------------
// binary_closing_3x3: streaming 3x3 morphological closing of a binary image
// Dilation and erosion run back to back in raster order over two row-delay
// memories; flush words drain the last 2W+2 pixels of each frame.
// ----------------------------------------------------------------------------
module binary_closing_3x3
    import clos_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [TDATA_BITS-1:0]    s_tdata,   // [0] pixel_in, rest zero
    input  logic                     s_tuser,   // [0] opcode
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [TDATA_BITS-1:0]    m_tdata,   // [0] pixel_out, rest zero
    output logic                     m_tlast,   // last_of_frame
    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0]  cfg_addr,
    input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

    localparam int COL_BITS  = $clog2(MAX_WIDTH);
    localparam int WEFF_BITS = $clog2(MAX_WIDTH + 1);
    localparam int ROW_BITS  = $clog2(MAX_HEIGHT);
    localparam int FILL_BITS = $clog2(2 * MAX_WIDTH + 3);

    function automatic int eff_w(input logic [CFG_W_BITS-1:0] raw);
        int v;
        v = int'(raw);
        if (v == 0) begin
            v = 1;
        end else if (v > MAX_WIDTH) begin
            v = MAX_WIDTH;
        end
        return v;
    endfunction

    function automatic int eff_h(input logic [CFG_H_BITS-1:0] raw);
        int v;
        v = int'(raw);
        if (v == 0) begin
            v = 1;
        end else if (v > MAX_HEIGHT) begin
            v = MAX_HEIGHT;
        end
        return v;
    endfunction

    // Configuration and derived frame geometry
    logic [CFG_W_BITS-1:0] cfg_width_reg, cfg_width_next;
    logic [CFG_H_BITS-1:0] cfg_height_reg, cfg_height_next;
    logic [WEFF_BITS-1:0]  w_eff_reg;
    logic [COL_BITS-1:0]   w_last_reg;
    logic [ROW_BITS-1:0]   h_last_reg;
    logic [FILL_BITS-1:0]  thr_reg;
    int                    w_int;
    int                    h_int;

    // Frame control
    logic [COL_BITS-1:0]  in_col_reg;
    logic [ROW_BITS-1:0]  in_row_reg;
    logic                 done_reg;
    logic                 pend_reg;
    logic [FILL_BITS-1:0] fill_reg;
    logic [COL_BITS-1:0]  dil_col_reg;
    logic [ROW_BITS-1:0]  dil_row_reg;
    logic [COL_BITS-1:0]  out_col_reg;
    logic [ROW_BITS-1:0]  out_row_reg;

    // Output register
    logic m_valid_reg;
    logic m_pix_reg;
    logic m_last_reg;

    logic                out_free;
    logic                in_acc;
    logic                caught_up;
    logic                pix_item;
    logic                drain_item;
    logic                catch_step;
    logic                pend_fire;
    logic                step;
    logic                emit;
    logic                in_last;
    logic                out_last;
    logic                frame_clr;
    logic                col_wrap;
    logic [COL_BITS-1:0] col_adv;
    logic [COL_BITS-1:0] lb_rd_addr;
    logic                pix_bit;
    logic                dil_active;
    win_mask_t           dil_mask;
    win_mask_t           ero_mask;
    logic [1:0]          in_rd;
    logic [1:0]          dil_rd;
    logic [2:0]          in_vec;
    logic [2:0]          dil_vec;
    logic                dil_bit;
    logic                close_bit;

    // Decode register writes
    always_comb begin
        cfg_width_next  = cfg_width_reg;
        cfg_height_next = cfg_height_reg;
        if (!aresetn) begin
            cfg_width_next  = RESET_WIDTH;
            cfg_height_next = RESET_HEIGHT;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_IMAGE_WIDTH: begin
                    cfg_width_next = cfg_wdata[CFG_W_BITS-1:0];
                end
                REG_IMAGE_HEIGHT: begin
                    cfg_height_next = cfg_wdata[CFG_H_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
        w_int = eff_w(cfg_width_next);
        h_int = eff_h(cfg_height_next);
    end

    // Hold registers and the clamped geometry they imply
    always_ff @(posedge aclk) begin
        cfg_width_reg  <= cfg_width_next;
        cfg_height_reg <= cfg_height_next;
        w_eff_reg      <= WEFF_BITS'(w_int);
        w_last_reg     <= COL_BITS'(w_int - 1);
        h_last_reg     <= ROW_BITS'(h_int - 1);
        thr_reg        <= FILL_BITS'(2 * w_int + 2);
    end

    // Handshake and step control
    always_comb begin
        out_free   = !m_valid_reg || m_tready;
        s_tready   = !pend_reg && out_free;
        in_acc     = s_tvalid && s_tready;
        caught_up  = (fill_reg == thr_reg);
        pix_item   = in_acc && (s_tuser != OP_FLUSH) && !done_reg;
        drain_item = in_acc && done_reg;
        catch_step = pend_reg && !caught_up;
        pend_fire  = pend_reg && caught_up && out_free;
        step       = pix_item || drain_item || catch_step || pend_fire;
        emit       = step && caught_up;
        in_last    = (in_row_reg == h_last_reg) && (in_col_reg == w_last_reg);
        out_last   = (out_row_reg == h_last_reg) && (out_col_reg == w_last_reg);
        frame_clr  = cfg_wr_en || (emit && out_last);
        col_wrap   = (in_col_reg == w_last_reg);
        col_adv    = col_wrap ? '0 : in_col_reg + 1'b1;
        lb_rd_addr = frame_clr ? '0 : (step ? col_adv : in_col_reg);
        pix_bit    = pix_item ? s_tdata[0] : 1'b0;
        dil_active = fill_reg > FILL_BITS'(w_eff_reg);
    end

    // Border masks for the dilation and erosion centers
    always_comb begin
        dil_mask.top    = (dil_row_reg == '0);
        dil_mask.bottom = (dil_row_reg == h_last_reg);
        dil_mask.left   = (dil_col_reg == '0);
        dil_mask.right  = (dil_col_reg == w_last_reg);
        ero_mask.top    = (out_row_reg == '0);
        ero_mask.bottom = (out_row_reg == h_last_reg);
        ero_mask.left   = (out_col_reg == '0);
        ero_mask.right  = (out_col_reg == w_last_reg);
    end

    // Advance the position counters
    always_ff @(posedge aclk) begin
        if (!aresetn || frame_clr) begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            done_reg    <= 1'b0;
            pend_reg    <= 1'b0;
            fill_reg    <= '0;
            dil_col_reg <= '0;
            dil_row_reg <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end else begin
            if (step) begin
                in_col_reg <= col_adv;
                if (!caught_up) begin
                    fill_reg <= fill_reg + 1'b1;
                end
                if (dil_active) begin
                    if (dil_col_reg == w_last_reg) begin
                        dil_col_reg <= '0;
                        dil_row_reg <= dil_row_reg + 1'b1;
                    end else begin
                        dil_col_reg <= dil_col_reg + 1'b1;
                    end
                end
            end
            if (pix_item && col_wrap) begin
                in_row_reg <= in_row_reg + 1'b1;
            end
            if (pix_item && in_last) begin
                done_reg <= 1'b1;
                if (!caught_up) begin
                    pend_reg <= 1'b1;
                end
            end
            if (pend_fire) begin
                pend_reg <= 1'b0;
            end
            if (emit) begin
                if (out_col_reg == w_last_reg) begin
                    out_col_reg <= '0;
                    out_row_reg <= out_row_reg + 1'b1;
                end else begin
                    out_col_reg <= out_col_reg + 1'b1;
                end
            end
        end
    end

    // Input rows: entry holds {row above-above, row above}
    clos_line_buf #(
        .DEPTH     (MAX_WIDTH),
        .DATA_BITS (2)
    ) u_in_lb (
        .aclk    (aclk),
        .wr_en   (step),
        .wr_addr (in_col_reg),
        .wr_data ({in_rd[0], pix_bit}),
        .rd_addr (lb_rd_addr),
        .rd_data (in_rd)
    );

    assign in_vec = {in_rd[1], in_rd[0], pix_bit};

    clos_win u_dil_win (
        .aclk     (aclk),
        .shift_en (step),
        .col_in   (in_vec),
        .mask     (dil_mask),
        .erode    (1'b0),
        .result   (dil_bit)
    );

    // Dilated rows
    clos_line_buf #(
        .DEPTH     (MAX_WIDTH),
        .DATA_BITS (2)
    ) u_dil_lb (
        .aclk    (aclk),
        .wr_en   (step),
        .wr_addr (in_col_reg),
        .wr_data ({dil_rd[0], dil_bit}),
        .rd_addr (lb_rd_addr),
        .rd_data (dil_rd)
    );

    assign dil_vec = {dil_rd[1], dil_rd[0], dil_bit};

    clos_win u_ero_win (
        .aclk     (aclk),
        .shift_en (step),
        .col_in   (dil_vec),
        .mask     (ero_mask),
        .erode    (1'b1),
        .result   (close_bit)
    );

    // Hold the result word until the master side takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_pix_reg  <= close_bit;
            m_last_reg <= out_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(TDATA_BITS-1){1'b0}}, m_pix_reg};
    assign m_tlast  = m_last_reg;

endmodule

// File: sv/clos_line_buf.sv
// ----------------------------------------------------------------------------
// clos_line_buf: one-row delay memory
// Written at the current column, read one column ahead so the registered
// read word is ready for the next pixel; a same-address write is bypassed.
// ----------------------------------------------------------------------------
module clos_line_buf #(
    parameter int DEPTH     = 1024,
    parameter int DATA_BITS = 2
) (
    input  logic                         aclk,
    input  logic                         wr_en,
    input  logic [$clog2(DEPTH)-1:0]     wr_addr,
    input  logic [DATA_BITS-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0]     rd_addr,
    output logic [DATA_BITS-1:0]         rd_data
);

    logic [DATA_BITS-1:0] mem [DEPTH];
    logic [DATA_BITS-1:0] rd_data_reg;

    // Write the new column word
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Prefetch the next column, forwarding a write to the same entry
    always_ff @(posedge aclk) begin
        if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_reg <= wr_data;
        end else begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/clos_win.sv
// ----------------------------------------------------------------------------
// clos_win: 3x3 binary window operator
// Holds the left and center column vectors, takes the right one live, and
// reduces the nine cells by OR (dilate) or AND (erode) with border cells
// forced to the identity of the operation.
// ----------------------------------------------------------------------------
module clos_win
    import clos_pkg::*;
(
    input  logic      aclk,
    input  logic      shift_en,
    input  logic [2:0] col_in,   // [2] row above, [1] center row, [0] row below
    input  win_mask_t mask,
    input  logic      erode,
    output logic      result
);

    logic [2:0] left_reg;
    logic [2:0] cen_reg;
    logic [2:0] row_off;
    logic [2:0] fill;
    logic [2:0] left_m;
    logic [2:0] cen_m;
    logic [2:0] right_m;

    // Advance the column window by one pixel
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            left_reg <= cen_reg;
            cen_reg  <= col_in;
        end
    end

    // Force cells outside the image to the neutral value
    always_comb begin
        row_off = {mask.top, 1'b0, mask.bottom};
        fill    = {3{erode}};
        left_m  = mask.left  ? fill : ((left_reg & ~row_off) | (fill & row_off));
        cen_m   = (cen_reg & ~row_off) | (fill & row_off);
        right_m = mask.right ? fill : ((col_in & ~row_off) | (fill & row_off));
        result  = erode ? (&{left_m, cen_m, right_m}) : (|{left_m, cen_m, right_m});
    end

endmodule

// File: tb/binary_closing_3x3_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_closing_3x3_tb: self-checking bench for the 3x3 binary closing block
// A queue-fed driver streams pixel and flush words into the block while a
// monitor takes the closed pixels under random backpressure. Each accepted
// word runs through an in-bench closing predictor, and every result is
// compared field by field against the oldest pending prediction. Runs cover
// saturated and zero frame sizes, aborted frames and random small frames.
// ----------------------------------------------------------------------------
module binary_closing_3x3_tb;
    import clos_pkg::*;

    localparam int MAX_W        = 1024;
    localparam int MAX_H        = 4096;
    localparam int RING         = 4 * MAX_W + 8;
    localparam int RANDOM_WORDS = 1350;
    localparam int QUIET_LIMIT  = 12000;
    localparam logic OP_PIXEL   = 1'b0;

    typedef struct {
        logic op;
        logic px;
        bit   hold;   // wait for every pending result before sending
        int   gap;    // idle cycles after this word
    } pix_word_t;

    typedef struct {
        logic px;
        logic last;
    } closed_px_t;

    logic                     aclk      = 1'b0;
    logic                     aresetn   = 1'b0;
    logic                     s_tvalid  = 1'b0;
    logic                     s_tready;
    logic [TDATA_BITS-1:0]    s_tdata   = '0;   // [0] pixel_in, rest zero
    logic                     s_tuser   = 1'b0; // [0] opcode
    logic                     m_tvalid;
    logic                     m_tready  = 1'b0;
    logic [TDATA_BITS-1:0]    m_tdata;          // [0] pixel_out, rest zero
    logic                     m_tlast;
    logic                     cfg_wr_en = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_addr  = '0;
    logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

    // Predictor state
    bit                       px_ring [RING];
    logic [CFG_W_BITS-1:0]    width_reg;
    logic [CFG_H_BITS-1:0]    height_reg;
    int                       in_row, in_col, out_row, out_col;
    bit                       in_done;
    closed_px_t               closed_q [$];

    // Stimulus state
    pix_word_t                word_q [$];
    pix_word_t                cur_word;
    int                       gap_left     = 0;
    int                       stall_left   = 0;
    int                       stall_pct    = 20;
    int                       idle_pct     = 10;
    bit                       calm         = 1'b0;
    int                       sent_words   = 0;
    int                       n_errors     = 0;
    int                       quiet_cycles = 0;

    binary_closing_3x3 DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #2 aclk = ~aclk;

    // Frame size as the block uses it: zero counts as one, big values clamp
    function automatic int eff_w();
        if (width_reg == '0) return 1;
        if (width_reg > MAX_W) return MAX_W;
        return int'(width_reg);
    endfunction

    function automatic int eff_h();
        if (height_reg == '0) return 1;
        if (height_reg > MAX_H) return MAX_H;
        return int'(height_reg);
    endfunction

    function automatic void clear_pos();
        in_row  = 0;
        in_col  = 0;
        out_row = 0;
        out_col = 0;
        in_done = 1'b0;
    endfunction

    // OR over the in-image 3x3 neighborhood of the input
    function automatic bit dilated_at(int r, int c, int w, int h);
        for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
                if (r + dr >= 0 && r + dr < h && c + dc >= 0 && c + dc < w) begin
                    if (px_ring[((r + dr) * w + c + dc) % RING]) return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    // AND of the dilation over the in-image 3x3 neighborhood
    function automatic bit closed_at(int r, int c, int w, int h);
        for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
                if (r + dr >= 0 && r + dr < h && c + dc >= 0 && c + dc < w) begin
                    if (!dilated_at(r + dr, c + dc, w, h)) return 1'b0;
                end
            end
        end
        return 1'b1;
    endfunction

    // Queue the next closed pixel and advance the output position
    function automatic void emit_closed(int w, int h);
        closed_px_t res;
        res.px   = closed_at(out_row, out_col, w, h);
        res.last = (out_row * w + out_col == w * h - 1);
        closed_q.push_back(res);
        if (res.last) begin
            clear_pos();
        end else begin
            out_col++;
            if (out_col >= w) begin
                out_col = 0;
                out_row++;
            end
        end
    endfunction

    // Work out what one accepted word causes
    function automatic void predict_closing(logic op, logic px);
        int w, h, got;
        w = eff_w();
        h = eff_h();
        if (op == OP_FLUSH || in_done) begin
            if (in_done) emit_closed(w, h);
            return;
        end
        got = in_row * w + in_col;
        px_ring[got % RING] = px;
        got++;
        in_col++;
        if (in_col >= w) begin
            in_col = 0;
            in_row++;
            if (in_row >= h) in_done = 1'b1;
        end
        if (in_done || got >= out_row * w + out_col + 2 * w + 3) emit_closed(w, h);
    endfunction

    function automatic void push_word(logic op, logic px, bit counted);
        pix_word_t wd;
        wd.op   = op;
        wd.px   = px;
        wd.hold = ($urandom_range(99) < 2);
        wd.gap  = (!calm && $urandom_range(99) < idle_pct) ? $urandom_range(1, 5) : 0;
        word_q.push_back(wd);
        if (counted) sent_words++;
    endfunction

    // Queue n_px pixels of a w x h frame; a complete frame gets its drain
    function automatic void send_frame(int w, int h, int n_px, bit noisy, bit counted);
        int dens, n_drain;
        dens = $urandom_range(0, 100);
        for (int i = 0; i < n_px; i++) begin
            if (noisy && $urandom_range(99) < 4) push_word(OP_FLUSH, $urandom_range(1), 1'b0);
            push_word(OP_PIXEL, $urandom_range(99) < dens, counted);
        end
        if (n_px == w * h) begin
            n_drain = (w * h - 1 < 2 * w + 2) ? w * h - 1 : 2 * w + 2;
            repeat (n_drain) begin
                push_word((noisy && $urandom_range(99) < 15) ? OP_PIXEL : OP_FLUSH,
                          $urandom_range(1), counted);
            end
        end
    endfunction

    // Wait until all words are sent and all results are in, then let the block settle
    task automatic settle();
        while (word_q.size() != 0 || s_tvalid || closed_q.size() != 0) @(negedge aclk);
        repeat (2 * eff_w() + 8) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, int unsigned val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= CFG_DATA_BITS'(val);
        @(posedge aclk);
        // the block takes the write at this edge and drops the frame in progress
        if (idx == REG_IMAGE_WIDTH) width_reg = CFG_W_BITS'(val);
        else height_reg = CFG_H_BITS'(val);
        clear_pos();
        cfg_wr_en <= 1'b0;
    endtask

    // Driver: hold a word until taken, insert gaps, honor hold-offs
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) predict_closing(cur_word.op, cur_word.px);
            if (s_tvalid && !s_tready) begin
                // keep the word on the bus
            end else if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (word_q.size() != 0 && !(word_q[0].hold && closed_q.size() != 0)) begin
                cur_word = word_q.pop_front();
                gap_left = cur_word.gap;
                s_tvalid <= 1'b1;
                s_tdata  <= TDATA_BITS'(cur_word.px);
                s_tuser  <= cur_word.op;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: check each closed pixel, stall in random bursts
    always @(posedge aclk) begin : monitor
        closed_px_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (closed_q.size() == 0) begin
                $error("unexpected word: pixel_out %0b last_of_frame %0b", m_tdata[0], m_tlast);
                n_errors++;
            end else begin
                want = closed_q.pop_front();
                if (m_tdata[0] !== want.px) begin
                    $error("pixel_out: expected %0b, got %0b", want.px, m_tdata[0]);
                    n_errors++;
                end
                if (m_tlast !== want.last) begin
                    $error("last_of_frame: expected %0b, got %0b", want.last, m_tlast);
                    n_errors++;
                end
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (!calm && $urandom_range(99) < stall_pct) begin
            stall_left = $urandom_range(0, 4);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
        // switch between calm and busy stretches now and then
        if ($urandom_range(255) == 0) stall_pct = ($urandom_range(2) == 0) ? 0 : 10 + 25 * $urandom_range(1);
    end

    // Watchdog: end the run if nothing moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("binary_closing_3x3_tb: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        bit [8:0] ring_img;
        int       cur_w, cur_h, roll, n_px;
        bit       must_write;

        width_reg  = RESET_WIDTH;
        height_reg = RESET_HEIGHT;
        clear_pos();
        ring_img   = 9'b111_101_111;
        must_write = 1'b1;
        cur_w      = 1;
        cur_h      = 1;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // a couple of pixels at the reset frame size: nothing comes out yet
        push_word(OP_PIXEL, 1'b1, 1'b0);
        push_word(OP_PIXEL, 1'b0, 1'b0);
        settle();

        // 1x1 frames: every pixel is its own frame end; idle flush does nothing
        write_reg(REG_IMAGE_WIDTH, 1);
        write_reg(REG_IMAGE_HEIGHT, 1);
        push_word(OP_PIXEL, 1'b1, 1'b0);
        push_word(OP_PIXEL, 1'b0, 1'b0);
        push_word(OP_FLUSH, 1'b1, 1'b0);
        settle();

        // zero sizes count as one
        write_reg(REG_IMAGE_WIDTH, 0);
        write_reg(REG_IMAGE_HEIGHT, 0);
        push_word(OP_PIXEL, 1'b1, 1'b0);
        push_word(OP_PIXEL, 1'b0, 1'b0);
        settle();

        // 3x3 ring with a hole: early flush ignored, pixel during drain acts as flush
        write_reg(REG_IMAGE_WIDTH, 3);
        write_reg(REG_IMAGE_HEIGHT, 3);
        for (int i = 0; i < 9; i++) begin
            if (i == 8) push_word(OP_FLUSH, 1'b0, 1'b0);
            push_word(OP_PIXEL, ring_img[i], 1'b0);
        end
        push_word(OP_PIXEL, 1'b1, 1'b0);
        repeat (7) push_word(OP_FLUSH, 1'b0, 1'b0);
        settle();

        // widest rows (saturated width), frame aborted after a few outputs
        write_reg(REG_IMAGE_WIDTH, 2047);
        write_reg(REG_IMAGE_HEIGHT, 3);
        send_frame(MAX_W, 3, 2 * MAX_W + 40, 1'b1, 1'b0);
        settle();

        // tallest frame (saturated height), one column, aborted
        write_reg(REG_IMAGE_HEIGHT, 8191);
        write_reg(REG_IMAGE_WIDTH, 1);
        send_frame(1, MAX_H, 60, 1'b1, 1'b0);
        settle();

        // random small frames, mostly complete, some aborted, some stray flushes
        while (sent_words < RANDOM_WORDS) begin
            if (sent_words > RANDOM_WORDS * 4 / 5) calm = 1'b1;
            roll     = $urandom_range(2);
            idle_pct = (roll == 0) ? 0 : ((roll == 1) ? 10 : 35);
            if (must_write || $urandom_range(99) < 35) begin
                settle();
                roll  = $urandom_range(99);
                cur_w = (roll < 80) ? $urandom_range(1, 10) :
                        ((roll < 95) ? $urandom_range(11, 40) : $urandom_range(41, 80));
                cur_h = ($urandom_range(99) < 85) ? $urandom_range(1, 8) : $urandom_range(9, 24);
                if ($urandom_range(1)) begin
                    write_reg(REG_IMAGE_WIDTH, cur_w);
                    write_reg(REG_IMAGE_HEIGHT, cur_h);
                end else begin
                    write_reg(REG_IMAGE_HEIGHT, cur_h);
                    write_reg(REG_IMAGE_WIDTH, cur_w);
                end
                must_write = 1'b0;
            end
            roll = $urandom_range(99);
            if (roll < 80) begin
                send_frame(cur_w, cur_h, cur_w * cur_h, $urandom_range(1), 1'b1);
            end else if (roll < 90 && cur_w * cur_h > 1) begin
                n_px = $urandom_range(1, cur_w * cur_h - 1);
                send_frame(cur_w, cur_h, n_px, 1'b1, 1'b1);
                must_write = 1'b1;
            end else begin
                repeat ($urandom_range(1, 3)) push_word(OP_FLUSH, $urandom_range(1), 1'b0);
            end
        end

        // drain and report
        calm = 1'b1;
        settle();
        repeat (16) @(posedge aclk);
        if (n_errors == 0) begin
            $display("binary_closing_3x3_tb: PASS");
        end else begin
            $display("binary_closing_3x3_tb: FAIL");
        end
        $finish;
    end

endmodule
